### design/llrc_pkg.sv
package llrc_pkg;

   // height fraction bits (0..8)
   localparam int LEVEL_FRACTION_BITS = 4;

   localparam int SAMPLE_W   = 16;
   localparam int HEIGHT_W   = 13;
   localparam int SETPOINT_W = 9;
   localparam int STEP_W     = 6;
   localparam int MODE_W     = 3;
   localparam int ERR_W      = 15;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT_MAX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COARSE_STEP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINE_STEP    = 2'd2;

   localparam logic [SETPOINT_W-1:0] SETPOINT_MAX_RST = 9'd300;
   localparam logic [STEP_W-1:0]     COARSE_STEP_RST  = 6'd10;
   localparam logic [STEP_W-1:0]     FINE_STEP_RST    = 6'd1;

   localparam logic [MODE_W-1:0] MODE_WATER    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GASOLINE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ALCOHOL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MILK     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_OIL      = 3'd4;

   // densities in hundredths
   localparam int DENS_WATER    = 100;
   localparam int DENS_GASOLINE = 70;
   localparam int DENS_ALCOHOL  = 79;
   localparam int DENS_MILK     = 103;
   localparam int DENS_OIL      = 90;

   // height = sample * SCALE * 2^F / (ADC_FULL * density)
   localparam int SCALE    = 35000;
   localparam int ADC_FULL = 65535;

   localparam int PROD_W = 32;                         // sample * SCALE
   localparam int REM_W  = PROD_W + LEVEL_FRACTION_BITS;
   localparam int QUOT_W = 9 + LEVEL_FRACTION_BITS;    // max quotient 500 * 2^F
   localparam int DVS_W  = 23;                         // ADC_FULL * 103
   localparam int CNT_W  = $clog2(QUOT_W);
   localparam int QSAT_W = (QUOT_W > HEIGHT_W) ? QUOT_W : HEIGHT_W;

   localparam int SPS_W  = SETPOINT_W + LEVEL_FRACTION_BITS;
   localparam int CMP_W  = (SPS_W > HEIGHT_W) ? SPS_W : HEIGHT_W;
   localparam int ERRC_W = (CMP_W + 1 > ERR_W) ? CMP_W + 1 : ERR_W;

   typedef struct packed {
      logic start;
      logic stop;
      logic change;
      logic sel;
      logic coarse_up;
      logic coarse_down;
      logic fine_up;
      logic fine_down;
   } btn_type;

   typedef struct packed {
      logic                  fill_relay;
      logic                  drain_relay;
      logic [HEIGHT_W-1:0]   level_height;
      logic [SETPOINT_W-1:0] setpoint_now;
      logic [MODE_W-1:0]     material_mode;
      logic                  running_flag;
   } rsp_type;

   // ADC_FULL * density; unknown codes read as water
   function automatic logic [DVS_W-1:0] density_divisor(input logic [MODE_W-1:0] sel);
      logic [DVS_W-1:0] d;
      case (sel)
         MODE_GASOLINE: d = DVS_W'(ADC_FULL * DENS_GASOLINE);
         MODE_ALCOHOL:  d = DVS_W'(ADC_FULL * DENS_ALCOHOL);
         MODE_MILK:     d = DVS_W'(ADC_FULL * DENS_MILK);
         MODE_OIL:      d = DVS_W'(ADC_FULL * DENS_OIL);
         default:       d = DVS_W'(ADC_FULL * DENS_WATER);
      endcase
      return d;
   endfunction

   function automatic logic [HEIGHT_W-1:0] sat_height(input logic [QUOT_W-1:0] q);
      logic [QSAT_W-1:0] qe;
      logic [HEIGHT_W-1:0] h;
      qe = QSAT_W'(q);
      if (qe > QSAT_W'((2 ** HEIGHT_W) - 1)) begin
         h = '1;
      end else begin
         h = qe[HEIGHT_W-1:0];
      end
      return h;
   endfunction

endpackage

### design/llrc_ifs.sv
interface llrc_req_if;
   logic                           valid;
   logic                           ready;
   logic [llrc_pkg::SAMPLE_W-1:0]  level_sample;
   logic                           start_pressed;
   logic                           stop_pressed;
   logic                           change_pressed;
   logic                           select_pressed;
   logic                           coarse_up;
   logic                           coarse_down;
   logic                           fine_up;
   logic                           fine_down;

   modport source (
      output valid, level_sample, start_pressed, stop_pressed, change_pressed,
             select_pressed, coarse_up, coarse_down, fine_up, fine_down,
      input  ready
   );
   modport sink (
      input  valid, level_sample, start_pressed, stop_pressed, change_pressed,
             select_pressed, coarse_up, coarse_down, fine_up, fine_down,
      output ready
   );
endinterface

interface llrc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            fill_relay;
   logic                            drain_relay;
   logic [llrc_pkg::HEIGHT_W-1:0]   level_height;
   logic [llrc_pkg::SETPOINT_W-1:0] setpoint_now;
   logic [llrc_pkg::MODE_W-1:0]     material_mode;
   logic                            running_flag;

   modport source (
      output valid, fill_relay, drain_relay, level_height, setpoint_now,
             material_mode, running_flag,
      input  ready
   );
   modport sink (
      input  valid, fill_relay, drain_relay, level_height, setpoint_now,
             material_mode, running_flag,
      output ready
   );
endinterface

### design/liquid_level_relay_controller.sv
// Liquid level relay controller. Each req item is one polling pass (a 16-bit
// level sample plus eight button flags) and yields exactly one rsp item with
// the relay drives, the computed height (Q.4), setpoint, material mode and
// run flag after that pass. The sample multiply feeds the divider at accept,
// then the shared subtract/compare divider resolves one quotient bit per
// cycle, hands the quotient over, and the button and relay update is applied
// once the rsp register is free. req_ready is high only while no pass is in
// flight; a finished result waits in the rsp register, and the next pass may
// be accepted meanwhile. The user must write the setpoint limit and step
// sizes through the csr port only while the block is idle; the block itself
// does not enforce this.
module liquid_level_relay_controller (
   input  logic                               clock,
   input  logic                               reset,
   llrc_req_if.sink                           req_ch,
   llrc_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [llrc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [llrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_POST} state_type;

   state_type                       state_ff, state_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   llrc_pkg::rsp_type               rsp_data_ff;
   llrc_pkg::btn_type               btn_ff;

   logic                            accept;
   logic                            apply;
   logic                            div_done;
   logic [llrc_pkg::HEIGHT_W-1:0]   height;
   logic [llrc_pkg::MODE_W-1:0]     density_select;
   llrc_pkg::rsp_type               result;

   assign req_ch.ready = state_ff == S_IDLE;
   assign accept       = req_ch.valid && req_ch.ready;

   // update lands only once the rsp register is free (or draining now)
   assign apply = (state_ff == S_POST) && (!rsp_valid_ff || rsp_ch.ready);

   llrc_divider u_divider (
      .clock          (clock),
      .reset          (reset),
      .start          (accept),
      .sample         (req_ch.level_sample),
      .density_select (density_select),
      .done           (div_done),
      .height         (height)
   );

   llrc_control u_control (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .apply          (apply),
      .height         (height),
      .btn            (btn_ff),
      .density_select (density_select),
      .result         (result)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (div_done) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (apply) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item payload holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         btn_ff.start       <= req_ch.start_pressed;
         btn_ff.stop        <= req_ch.stop_pressed;
         btn_ff.change      <= req_ch.change_pressed;
         btn_ff.sel         <= req_ch.select_pressed;
         btn_ff.coarse_up   <= req_ch.coarse_up;
         btn_ff.coarse_down <= req_ch.coarse_down;
         btn_ff.fine_up     <= req_ch.fine_up;
         btn_ff.fine_down   <= req_ch.fine_down;
      end
      if (apply) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.fill_relay    = rsp_data_ff.fill_relay;
   assign rsp_ch.drain_relay   = rsp_data_ff.drain_relay;
   assign rsp_ch.level_height  = rsp_data_ff.level_height;
   assign rsp_ch.setpoint_now  = rsp_data_ff.setpoint_now;
   assign rsp_ch.material_mode = rsp_data_ff.material_mode;
   assign rsp_ch.running_flag  = rsp_data_ff.running_flag;

endmodule

### design/llrc_divider.sv
// Height unit: one multiply on start, then a restoring divider that
// resolves one quotient bit per cycle with a single subtract/compare.
module llrc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [llrc_pkg::SAMPLE_W-1:0]     sample,
   input  logic [llrc_pkg::MODE_W-1:0]       density_select,
   output logic                              done,
   output logic [llrc_pkg::HEIGHT_W-1:0]     height
);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_type;

   dstate_type                       state_ff, state_in;
   logic [llrc_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [llrc_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [llrc_pkg::REM_W-1:0]       sdv_ff, sdv_in;
   logic [llrc_pkg::QUOT_W-1:0]      quot_ff, quot_in;
   logic [llrc_pkg::PROD_W-1:0]      prod;
   logic                             ge;

   assign prod = llrc_pkg::PROD_W'(sample) * llrc_pkg::PROD_W'(llrc_pkg::SCALE);
   assign ge   = rem_ff >= sdv_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      sdv_in   = sdv_ff;
      quot_in  = quot_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in   = llrc_pkg::REM_W'(prod) << llrc_pkg::LEVEL_FRACTION_BITS;
               sdv_in   = llrc_pkg::REM_W'(llrc_pkg::density_divisor(density_select))
                          << (llrc_pkg::QUOT_W - 1);
               cnt_in   = llrc_pkg::CNT_W'(llrc_pkg::QUOT_W - 1);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (ge) begin
               rem_in = rem_ff - sdv_ff;
            end
            quot_in = {quot_ff[llrc_pkg::QUOT_W-2:0], ge};
            sdv_in  = sdv_ff >> 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = D_DONE;
            end
         end
         D_DONE: begin
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sdv_ff  <= sdv_in;
      quot_ff <= quot_in;
   end

   assign done   = state_ff == D_DONE;
   assign height = llrc_pkg::sat_height(quot_ff);

endmodule

### design/llrc_control.sv
// Controller state, settings registers and the per-pass update.
module llrc_control (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [llrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [llrc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                apply,
   input  logic [llrc_pkg::HEIGHT_W-1:0]       height,
   input  llrc_pkg::btn_type                   btn,
   output logic [llrc_pkg::MODE_W-1:0]         density_select,
   output llrc_pkg::rsp_type                   result
);

   localparam logic signed [llrc_pkg::ERRC_W-1:0] ERR_HI =
      llrc_pkg::ERRC_W'((2 ** (llrc_pkg::ERR_W - 1)) - 1);
   localparam logic signed [llrc_pkg::ERRC_W-1:0] ERR_LO = ~ERR_HI;

   logic [llrc_pkg::SETPOINT_W-1:0]  sp_max_ff;
   logic [llrc_pkg::STEP_W-1:0]      coarse_ff, fine_ff;

   logic                             running_ff, running_in;
   logic [llrc_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [llrc_pkg::MODE_W-1:0]      dsel_ff, dsel_in;
   logic [llrc_pkg::SETPOINT_W-1:0]  setpoint_ff, setpoint_in;
   logic signed [llrc_pkg::ERR_W-1:0] err_ff, err_in;
   logic                             fill_act_ff, fill_act_in;
   logic                             drain_act_ff, drain_act_in;
   logic                             fill_drv_ff, fill_drv_in;
   logic                             drain_drv_ff, drain_drv_in;

   logic [llrc_pkg::SETPOINT_W:0]    up_coarse, up_fine, sp_max_x;
   logic [llrc_pkg::SPS_W-1:0]       sps;
   logic [llrc_pkg::CMP_W-1:0]       sps_c, height_c;
   logic signed [llrc_pkg::ERRC_W-1:0] diff;

   assign sp_max_x  = {1'b0, sp_max_ff};
   assign up_coarse = {1'b0, setpoint_ff} + (llrc_pkg::SETPOINT_W + 1)'(coarse_ff);
   assign up_fine   = {1'b0, setpoint_ff} + (llrc_pkg::SETPOINT_W + 1)'(fine_ff);
   assign sps       = llrc_pkg::SPS_W'(setpoint_in) << llrc_pkg::LEVEL_FRACTION_BITS;
   assign sps_c     = llrc_pkg::CMP_W'(sps);
   assign height_c  = llrc_pkg::CMP_W'(height);
   assign diff      = $signed(llrc_pkg::ERRC_W'(sps)) - $signed(llrc_pkg::ERRC_W'(height));

   always_comb begin
      running_in   = running_ff;
      mode_in      = mode_ff;
      dsel_in      = dsel_ff;
      setpoint_in  = setpoint_ff;
      err_in       = err_ff;
      fill_act_in  = fill_act_ff;
      drain_act_in = drain_act_ff;
      fill_drv_in  = fill_drv_ff;
      drain_drv_in = drain_drv_ff;

      // start wins; stop drops the drives but keeps the active flags
      if (btn.start) begin
         running_in = 1'b1;
      end else if (btn.stop) begin
         fill_drv_in  = 1'b0;
         drain_drv_in = 1'b0;
         running_in   = 1'b0;
      end

      if (!running_in) begin
         if (btn.change) begin
            mode_in = (mode_ff >= llrc_pkg::MODE_OIL) ? llrc_pkg::MODE_WATER
                                                      : mode_ff + 1'b1;
         end else if (btn.sel) begin
            dsel_in = mode_ff;
         end

         if (btn.coarse_up && up_coarse <= sp_max_x) begin
            setpoint_in = up_coarse[llrc_pkg::SETPOINT_W-1:0];
         end else if (btn.coarse_down &&
                      setpoint_ff >= llrc_pkg::SETPOINT_W'(coarse_ff)) begin
            setpoint_in = setpoint_ff - llrc_pkg::SETPOINT_W'(coarse_ff);
         end else if (btn.fine_up && up_fine <= sp_max_x) begin
            setpoint_in = up_fine[llrc_pkg::SETPOINT_W-1:0];
         end else if (btn.fine_down &&
                      setpoint_ff >= llrc_pkg::SETPOINT_W'(fine_ff)) begin
            setpoint_in = setpoint_ff - llrc_pkg::SETPOINT_W'(fine_ff);
         end

         if (diff > ERR_HI) begin
            err_in = ERR_HI[llrc_pkg::ERR_W-1:0];
         end else if (diff < ERR_LO) begin
            err_in = ERR_LO[llrc_pkg::ERR_W-1:0];
         end else begin
            err_in = diff[llrc_pkg::ERR_W-1:0];
         end
      end else begin
         if (!err_ff[llrc_pkg::ERR_W-1] && err_ff != '0) begin
            fill_drv_in = 1'b1;
            fill_act_in = 1'b1;
         end else if (err_ff[llrc_pkg::ERR_W-1]) begin
            drain_drv_in = 1'b1;
            drain_act_in = 1'b1;
         end
         if (fill_act_in && height_c >= sps_c) begin
            fill_drv_in = 1'b0;
            fill_act_in = 1'b0;
            err_in      = '0;
         end else if (drain_act_in && height_c <= sps_c) begin
            drain_drv_in = 1'b0;
            drain_act_in = 1'b0;
            err_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_max_ff    <= llrc_pkg::SETPOINT_MAX_RST;
         coarse_ff    <= llrc_pkg::COARSE_STEP_RST;
         fine_ff      <= llrc_pkg::FINE_STEP_RST;
         running_ff   <= 1'b0;
         mode_ff      <= llrc_pkg::MODE_WATER;
         dsel_ff      <= llrc_pkg::MODE_WATER;
         setpoint_ff  <= '0;
         err_ff       <= '0;
         fill_act_ff  <= 1'b0;
         drain_act_ff <= 1'b0;
         fill_drv_ff  <= 1'b0;
         drain_drv_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               llrc_pkg::CSR_SETPOINT_MAX: sp_max_ff <= csr_wdata;
               llrc_pkg::CSR_COARSE_STEP:  coarse_ff <= csr_wdata[llrc_pkg::STEP_W-1:0];
               llrc_pkg::CSR_FINE_STEP:    fine_ff   <= csr_wdata[llrc_pkg::STEP_W-1:0];
               default: ;
            endcase
         end
         if (apply) begin
            running_ff   <= running_in;
            mode_ff      <= mode_in;
            dsel_ff      <= dsel_in;
            setpoint_ff  <= setpoint_in;
            err_ff       <= err_in;
            fill_act_ff  <= fill_act_in;
            drain_act_ff <= drain_act_in;
            fill_drv_ff  <= fill_drv_in;
            drain_drv_ff <= drain_drv_in;
         end
      end
   end

   assign density_select = dsel_ff;

   always_comb begin
      result.fill_relay    = fill_drv_in;
      result.drain_relay   = drain_drv_in;
      result.level_height  = height;
      result.setpoint_now  = setpoint_in;
      result.material_mode = mode_in;
      result.running_flag  = running_in;
   end

endmodule
